// ===== rtl/nbc_pkg.sv =====
package nbc_pkg;

    localparam logic       CMD_TRAIN    = 1'b0;
    localparam logic       CMD_CLASSIFY = 1'b1;

    localparam logic       CFG_FEATURES = 1'b0;
    localparam logic       CFG_K        = 1'b1;

    localparam logic [7:0] BLANK_CHAR   = 8'h20;

    localparam int         CLASS_W      = 3;
    localparam int         SCORE_W      = 32;
    localparam int         TOTAL_W      = 19;
    localparam int         FLEN_W       = 10;
    localparam int         K_W          = 16;
    // wide enough for a score plus one log difference
    localparam int         SUM_W        = 34;

    localparam logic [FLEN_W-1:0]  FLEN_RESET = 10'd390;
    localparam logic [K_W-1:0]     K_RESET    = 16'd307;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 19'h7FFFF;

    typedef struct packed {
        logic v;
        logic first;
        logic last;
    } t_side;

    function automatic logic signed [SCORE_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(32'sh7FFF_FFFF);
        lo = SUM_W'(-33'sd2147483648);
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[SCORE_W-1:0];
    endfunction

endpackage

// ===== rtl/nbc_count_bank.sv =====
module nbc_count_bank #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata
);

    logic [DW-1:0] r_mem [0:DEPTH-1];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/nbc_log2.sv =====
module nbc_log2 #(
    parameter int W  = 16,
    parameter int F  = 10,
    parameter int EW = $clog2(W)
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [W-1:0]    i_x,
    output logic [EW+F-1:0] o_log
);

    logic [EW-1:0]  n_e;
    logic [W+29:0]  n_sh;
    logic [EW-1:0]  r_e [0:F];
    logic [30:0]    r_y [0:F];
    logic [F-1:0]   r_f [0:F];

    // leading one and normalize to q1.30
    always_comb begin
        n_e = '0;
        for (int i = 0; i < W; i++) begin
            if (i_x[i]) begin
                n_e = EW'(i);
            end
        end
        n_sh = {i_x, 30'b0} >> n_e;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e[0] <= n_e;
            r_y[0] <= n_sh[30:0];
            r_f[0] <= '0;
        end
    end

    // one fraction bit per stage by squaring
    for (genvar k = 1; k <= F; k++) begin : g_sq
        logic [61:0] n_p;
        logic [31:0] n_t;
        assign n_p = {31'b0, r_y[k-1]} * {31'b0, r_y[k-1]};
        assign n_t = n_p[61:30];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_e[k] <= r_e[k-1];
                r_f[k] <= {r_f[k-1][F-2:0], n_t[31]};
                r_y[k] <= n_t[31] ? n_t[31:1] : n_t[30:0];
            end
        end
    end

    assign o_log = {r_e[F], r_f[F]};

endmodule

// ===== rtl/naive_bayes_pixel_classifier_unit.sv =====
// naive bayes pixel classifier: one pixel item per cycle unless stalled, train
// or classify. per-class count banks (synchronous ram, 2*NUM_FEATURES words
// each) are read in parallel; a training increment is written from the
// registered read data, and a one-entry forward register covers a read of the
// same word by the next item. classify items run through log2 pipelines of
// LOG_FRAC_BITS+1 stages (a normalize stage, then one squaring each), then a
// score update stage and an argmax stage; a result item is given for the last
// pixel of each classified image. sustained rate is one item per cycle when
// nothing stalls. after reset a clearing pass zeroes all 2*NUM_FEATURES bank
// rows, one row a cycle; input is stalled then while configuration writes are
// taken. the whole pipeline holds while a result waits on a stalled output.
module naive_bayes_pixel_classifier_unit import nbc_pkg::*; #(
    parameter int NUM_CLASSES   = 5,
    parameter int NUM_FEATURES  = 512,
    parameter int COUNT_BITS    = 16,
    parameter int LOG_FRAC_BITS = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_command,
    input  logic [7:0]                i_pixel_char,
    input  logic [CLASS_W-1:0]        i_class_label,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [CLASS_W-1:0]        o_decided_class,
    output logic signed [SCORE_W-1:0] o_best_score,
    output logic                      o_none_trained,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_index,
    input  logic [K_W-1:0]            i_cfg_data
);

    localparam int NC    = NUM_CLASSES;
    localparam int CB    = COUNT_BITS;
    localparam int F     = LOG_FRAC_BITS;
    localparam int CW    = $clog2(NC);
    localparam int PW    = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int AW    = PW + 1;
    localparam int DEPTH = NUM_FEATURES * 2;
    localparam int NW    = CB + 9;
    localparam int LNW   = $clog2(NW) + F;
    localparam int LCW   = $clog2(CB) + F;
    localparam int LTW   = $clog2(TOTAL_W) + F;

    localparam logic [CB-1:0] CNT_MAX = '1;

    // configuration
    logic [FLEN_W-1:0] r_flen;
    logic [K_W-1:0]    r_k;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flen <= FLEN_RESET;
            r_k    <= K_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FEATURES: r_flen <= i_cfg_data[FLEN_W-1:0];
                CFG_K:        r_k    <= i_cfg_data;
                default:      r_k    <= r_k;
            endcase
        end
    end

    // clearing pass and flow control
    logic          r_clearing;
    logic [AW-1:0] r_clr;
    logic          r_out_valid;
    logic          en;
    logic          in_acc;

    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = r_clearing || !en;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr      <= '0;
        end else if (r_clearing) begin
            r_clr <= r_clr + 1'b1;
            if (r_clr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // pixel position and accept stage
    logic [PW-1:0] r_pos;
    logic [PW:0]   flen;
    logic          n_first;
    logic          n_last;
    logic          n_ink;
    logic [AW-1:0] n_addr;

    always_comb begin
        if (r_flen == '0) begin
            flen = (PW+1)'(1);
        end else if (32'(r_flen) > 32'(NUM_FEATURES)) begin
            flen = (PW+1)'(NUM_FEATURES);
        end else begin
            flen = (PW+1)'(r_flen);
        end
        n_first = (r_pos == '0);
        n_last  = ({1'b0, r_pos} + 1'b1) >= flen;
        n_ink   = (i_pixel_char != BLANK_CHAR);
        n_addr  = {r_pos, n_ink};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (in_acc) begin
            r_pos <= n_last ? '0 : r_pos + 1'b1;
        end
    end

    logic               r_s1_v;
    logic               r_s1_cmd;
    logic [CLASS_W-1:0] r_s1_lbl;
    logic               r_s1_first;
    logic               r_s1_last;
    logic [AW-1:0]      r_s1_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_cmd   <= i_command;
            r_s1_lbl   <= i_class_label;
            r_s1_first <= n_first;
            r_s1_last  <= n_last;
            r_s1_addr  <= n_addr;
        end
    end

    // count banks with read-modify-write
    logic [CB-1:0]      rdata [0:NC-1];
    logic [CB-1:0]      cnt   [0:NC-1];
    logic               r_fw_v;
    logic [CW-1:0]      r_fw_bank;
    logic [AW-1:0]      r_fw_addr;
    logic [CB-1:0]      r_fw_data;
    logic [CW-1:0]      li;
    logic               tr;
    logic               cl;
    logic [CB-1:0]      inc;
    logic [CB-1:0]      r_cc [0:NC-1];
    logic [TOTAL_W-1:0] r_total;
    logic [NC-1:0]      mask;

    assign li = CW'(r_s1_lbl);
    assign tr = r_s1_v && (r_s1_cmd == CMD_TRAIN) && (32'(r_s1_lbl) < NC);
    assign cl = r_s1_v && (r_s1_cmd == CMD_CLASSIFY);

    for (genvar c = 0; c < NC; c++) begin : g_bank
        logic we;
        assign we = r_clearing || (en && tr && (li == CW'(c)));
        nbc_count_bank #(.DEPTH(DEPTH), .AW(AW), .DW(CB)) u_bank (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_raddr (n_addr),
            .o_rdata (rdata[c]),
            .i_we    (we),
            .i_waddr (r_clearing ? r_clr : r_s1_addr),
            .i_wdata (r_clearing ? '0 : inc)
        );
        // word written at the edge of this read
        assign cnt[c]  = (r_fw_v && r_fw_bank == CW'(c) && r_fw_addr == r_s1_addr)
                         ? r_fw_data : rdata[c];
        assign mask[c] = (r_cc[c] != '0);
    end

    assign inc = (cnt[li] == CNT_MAX) ? cnt[li] : cnt[li] + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_v <= 1'b0;
        end else if (en) begin
            r_fw_v <= tr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fw_bank <= li;
            r_fw_addr <= r_s1_addr;
            r_fw_data <= inc;
        end
    end

    // class totals count trained images at their first pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NC; c++) begin
                r_cc[c] <= '0;
            end
            r_total <= '0;
        end else if (en && tr && r_s1_first && r_cc[li] != CNT_MAX) begin
            r_cc[li] <= r_cc[li] + 1'b1;
            if (r_total != TOTAL_MAX) begin
                r_total <= r_total + 1'b1;
            end
        end
    end

    // log pipelines
    logic [K_W-1:0] k_eff;
    logic [LNW-1:0] lnum [0:NC-1];
    logic [LNW-1:0] lden [0:NC-1];
    logic [LCW-1:0] lcc  [0:NC-1];
    logic [LTW-1:0] ltot;

    assign k_eff = (r_k == '0) ? K_W'(1) : r_k;

    for (genvar c = 0; c < NC; c++) begin : g_log
        logic [NW-1:0] num;
        logic [NW-1:0] den;
        assign num = {1'b0, cnt[c], 8'b0} + NW'(k_eff);
        assign den = {1'b0, r_cc[c], 8'b0} + NW'({k_eff, 1'b0});
        nbc_log2 #(.W(NW), .F(F)) u_num (
            .i_clk (i_clk), .i_en (en), .i_x (num), .o_log (lnum[c])
        );
        nbc_log2 #(.W(NW), .F(F)) u_den (
            .i_clk (i_clk), .i_en (en), .i_x (den), .o_log (lden[c])
        );
        nbc_log2 #(.W(CB), .F(F)) u_cc (
            .i_clk (i_clk), .i_en (en), .i_x (r_cc[c]), .o_log (lcc[c])
        );
    end

    nbc_log2 #(.W(TOTAL_W), .F(F)) u_tot (
        .i_clk (i_clk), .i_en (en), .i_x (r_total), .o_log (ltot)
    );

    // side info travels beside the log pipelines
    t_side         r_sb   [0:F];
    logic [NC-1:0] r_mask [0:F];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= F; s++) begin
                r_sb[s] <= '0;
            end
        end else if (en) begin
            r_sb[0] <= '{v: cl, first: r_s1_first, last: r_s1_last};
            for (int s = 1; s <= F; s++) begin
                r_sb[s] <= r_sb[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mask[0] <= mask;
            for (int s = 1; s <= F; s++) begin
                r_mask[s] <= r_mask[s-1];
            end
        end
    end

    // score update
    logic signed [SCORE_W-1:0] r_score   [0:NC-1];
    logic signed [SCORE_W-1:0] n_score   [0:NC-1];
    logic                      r_d_v;
    logic signed [SCORE_W-1:0] r_d_score [0:NC-1];
    logic [NC-1:0]             r_d_mask;

    always_comb begin
        logic signed [SCORE_W-1:0] pri;
        logic signed [SCORE_W-1:0] base;
        for (int c = 0; c < NC; c++) begin
            pri = r_mask[F][c] ? sat32(SUM_W'(lcc[c]) - SUM_W'(ltot)) : '0;
            base = r_sb[F].first ? pri : r_score[c];
            n_score[c] = sat32(SUM_W'(base) + SUM_W'(lnum[c]) - SUM_W'(lden[c]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_sb[F].v) begin
            for (int c = 0; c < NC; c++) begin
                r_score[c]   <= n_score[c];
                r_d_score[c] <= n_score[c];
            end
            r_d_mask <= r_mask[F];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (en) begin
            r_d_v <= r_sb[F].v && r_sb[F].last;
        end
    end

    // decision, lowest index wins ties
    logic                      any;
    logic [CW-1:0]             best;
    logic signed [SCORE_W-1:0] best_val;

    always_comb begin
        any      = 1'b0;
        best     = '0;
        best_val = '0;
        for (int c = 0; c < NC; c++) begin
            if (r_d_mask[c] && (!any || r_d_score[c] > best_val)) begin
                any      = 1'b1;
                best     = CW'(c);
                best_val = r_d_score[c];
            end
        end
    end

    logic [CLASS_W-1:0]        r_class;
    logic signed [SCORE_W-1:0] r_best;
    logic                      r_none;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_d_v) begin
            r_class <= CLASS_W'(best);
            r_best  <= best_val;
            r_none  <= !any;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_decided_class = r_class;
    assign o_best_score    = r_best;
    assign o_none_trained  = r_none;

    // checks
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> o_in_stall)
        else $error("item accepted during clearing pass");

    a_clear_no_items: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_s1_v)
        else $error("count write collides with clearing pass");

    a_none_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_none_trained) |-> (o_best_score == '0 && o_decided_class == '0))
        else $error("untrained result is not zero");

endmodule
